/* rtl/core/spr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the servo packet receiver: register indexes,
// input kinds, event codes and the result record.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] REG_DEVICE_ID     = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT_LIMIT = 2'd1;

    localparam logic [7:0] DEVICE_ID_RESET     = 8'd1;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd200;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] HEADER_BYTE    = 8'hFF;
    localparam logic [7:0] MAX_INSTR      = 8'h06;
    localparam logic [7:0] EXT_INSTR      = 8'h86;
    localparam logic [7:0] LENGTH_OFFSET  = 8'd2;
    localparam logic [7:0] TICKS_SATURATE = 8'hFF;

    localparam logic [2:0] EV_INSTR    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_GOOD     = 3'd2;
    localparam logic [2:0] EV_BADSUM   = 3'd3;
    localparam logic [2:0] EV_BADINSTR = 3'd4;

    typedef struct packed {
        logic [2:0] event_code;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] payload_count;
    } result_t;

    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] timeout_limit;
    } cfg_t;

endpackage

/* rtl/core/spr_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_cfg_regs
// Configuration register file: bus identifier and idle timeout limit.
// ----------------------------------------------------------------------------
module spr_cfg_regs
    import spr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [7:0]               cfg_data,
    output cfg_t                     cfg
);

    logic [7:0] device_id_reg;
    logic [7:0] timeout_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg     <= DEVICE_ID_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEVICE_ID:     device_id_reg     <= cfg_data;
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.device_id     = device_id_reg;
    assign cfg.timeout_limit = timeout_limit_reg;

endmodule

/* rtl/core/spr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_parser
// Input register and frame parser. One buffered item is parsed per cycle unless
// its result must wait for room; its result, if any, is pushed into the output register.
// ----------------------------------------------------------------------------
module spr_parser
    import spr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    input  logic       res_room,
    output logic       res_push,
    output result_t    res
);

    typedef enum logic [5:0] {
        PH_HDR1  = 6'b000001,
        PH_HDR2  = 6'b000010,
        PH_ID    = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_INSTR = 6'b010000,
        PH_BODY  = 6'b100000
    } phase_t;

    logic       s1_valid_reg;
    logic       s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_go;
    logic       res_valid;

    phase_t     phase_reg,          phase_next;
    logic [7:0] payload_length_reg, payload_length_next;
    logic [7:0] fill_index_reg,     fill_index_next;
    logic [7:0] running_sum_reg,    running_sum_next;
    logic [7:0] idle_ticks_reg,     idle_ticks_next;

    logic       timed_out;
    phase_t     cur_phase;
    logic [7:0] cur_fill;
    logic [7:0] cur_idle;
    logic [7:0] expect_sum;
    logic       b_is_header;
    phase_t     resync_phase;

    // An item without a result never waits for the output register.
    assign s1_go    = s1_valid_reg && (!res_valid || res_room);
    assign in_ready = !s1_valid_reg || s1_go;
    assign res_push = s1_go && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_kind_reg <= kind;
            s1_byte_reg <= rx_byte;
        end
    end

    assign timed_out    = (idle_ticks_reg >= cfg.timeout_limit);
    assign cur_phase    = timed_out ? PH_HDR1 : phase_reg;
    assign cur_fill     = timed_out ? 8'd0 : fill_index_reg;
    assign cur_idle     = timed_out ? 8'd0 : idle_ticks_reg;
    assign expect_sum   = ~(running_sum_reg + cfg.device_id);
    assign b_is_header  = (s1_byte_reg == HEADER_BYTE);
    assign resync_phase = b_is_header ? PH_HDR2 : PH_HDR1;

    always_comb
    begin
        phase_next          = phase_reg;
        payload_length_next = payload_length_reg;
        fill_index_next     = fill_index_reg;
        running_sum_next    = running_sum_reg;
        idle_ticks_next     = idle_ticks_reg;
        res_valid           = 1'b0;
        res.event_code      = EV_INSTR;
        res.byte_value      = s1_byte_reg;
        res.byte_index      = 8'd0;
        res.payload_count   = payload_length_reg;

        if (s1_kind_reg == KIND_TICK)
        begin
            if (idle_ticks_reg != TICKS_SATURATE)
            begin
                idle_ticks_next = idle_ticks_reg + 8'd1;
            end
        end
        else
        begin
            phase_next      = cur_phase;
            fill_index_next = cur_fill;
            idle_ticks_next = cur_idle;
            case (cur_phase)
                PH_HDR2:
                begin
                    phase_next = b_is_header ? PH_ID : PH_HDR1;
                end
                PH_ID:
                begin
                    phase_next = (s1_byte_reg == cfg.device_id) ? PH_LEN : PH_HDR1;
                end
                PH_LEN:
                begin
                    payload_length_next = s1_byte_reg - LENGTH_OFFSET;
                    running_sum_next    = s1_byte_reg;
                    phase_next          = PH_INSTR;
                end
                PH_INSTR:
                begin
                    res_valid = 1'b1;
                    if (s1_byte_reg > MAX_INSTR && s1_byte_reg != EXT_INSTR)
                    begin
                        phase_next     = resync_phase;
                        res.event_code = EV_BADINSTR;
                    end
                    else
                    begin
                        running_sum_next = running_sum_reg + s1_byte_reg;
                        phase_next       = PH_BODY;
                        res.event_code   = EV_INSTR;
                    end
                end
                PH_BODY:
                begin
                    res_valid = 1'b1;
                    if (cur_fill < payload_length_reg)
                    begin
                        running_sum_next = running_sum_reg + s1_byte_reg;
                        fill_index_next  = cur_fill + 8'd1;
                        res.event_code   = EV_PAYLOAD;
                        res.byte_index   = cur_fill;
                    end
                    else
                    begin
                        fill_index_next = 8'd0;
                        if (expect_sum == s1_byte_reg)
                        begin
                            phase_next     = PH_HDR1;
                            res.event_code = EV_GOOD;
                        end
                        else
                        begin
                            phase_next     = resync_phase;
                            res.event_code = EV_BADSUM;
                        end
                    end
                end
                default:
                begin
                    phase_next = resync_phase;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HDR1;
            payload_length_reg <= 8'd0;
            fill_index_reg     <= 8'd0;
            running_sum_reg    <= 8'd0;
            idle_ticks_reg     <= 8'd0;
        end
        else if (s1_go)
        begin
            phase_reg          <= phase_next;
            payload_length_reg <= payload_length_next;
            fill_index_reg     <= fill_index_next;
            running_sum_reg    <= running_sum_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_byte_reg)
                                   && $stable(s1_kind_reg))
        else $error("buffered item changed while stalled");

    a_tick_keeps_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_kind_reg == KIND_TICK |=> $stable(phase_reg)
                                              && $stable(running_sum_reg)
                                              && $stable(fill_index_reg))
        else $error("tick disturbed the frame state");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_kind_reg == KIND_TICK && idle_ticks_reg != TICKS_SATURATE
        |=> idle_ticks_reg == 8'($past(idle_ticks_reg) + 8'd1))
        else $error("tick not counted");

    a_payload_advances: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.event_code == EV_PAYLOAD
        |=> fill_index_reg == 8'($past(res.byte_index) + 8'd1))
        else $error("fill index out of step with payload events");
`endif

endmodule

/* rtl/core/spr_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_out_reg
// Result register that holds one event until the receiver takes it.
// ----------------------------------------------------------------------------
module spr_out_reg
    import spr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res,
    output logic    res_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    assign res_room       = !out_valid_reg || out_ready;
    assign out_valid_next = res_push || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/servo_packet_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_packet_receiver
// Byte-serial parser for FF FF id length instruction payload checksum frames.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one item per transaction:
// kind 0 is a received byte in rx_byte, kind 1 is one timer tick. Ticks feed
// a saturating idle counter; the first byte after it reaches timeout_limit
// restarts the parser. The output channel (out_valid/out_ready) carries at
// most one event per input item: instruction accepted or rejected, each
// payload byte with its index, and a checksum verdict closing the frame.
// The configuration channel (cfg_valid/cfg_ready) writes device_id
// (index 0) or timeout_limit (index 1); it is always ready and is meant to
// be used while the block is idle.
// An event is registered twice: its item is first captured in the input
// register, and its result then in the result register that drives out_valid.
// Throughput: one item per cycle unless a result waits for room, set by the
// single parse stage between the input register and the result register.
// When the receiver stalls, the result register holds its event, one more
// item is buffered, and in_ready drops only once that buffered item has a
// result to deliver. Reset empties both registers, returns the parser to
// awaiting the first header and loads device_id 1 and timeout_limit 200.
// ----------------------------------------------------------------------------
module servo_packet_receiver
    import spr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               event_code,
    output logic [7:0]               byte_value,
    output logic [7:0]               byte_index,
    output logic [7:0]               payload_count,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [7:0]               cfg_data
);

    cfg_t    cfg;
    logic    res_room;
    logic    res_push;
    result_t res;
    result_t out_data;

    spr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .rx_byte  (rx_byte),
        .cfg      (cfg),
        .res_room (res_room),
        .res_push (res_push),
        .res      (res)
    );

    spr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_room  (res_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign event_code    = out_data.event_code;
    assign byte_value    = out_data.byte_value;
    assign byte_index    = out_data.byte_index;
    assign payload_count = out_data.payload_count;

endmodule
